@@ hw/rtl/itke_pkg.sv @@
`default_nettype none
package itke_pkg;

   localparam int unsigned CordicStepsDefault = 20;
   localparam int unsigned AngW = 36;
   localparam logic signed [AngW-1:0] HalfTurn = 36'sd11796480;

   localparam logic [1:0] CSR_GYRO_SCALE  = 2'd0;
   localparam logic [1:0] CSR_DRIFT_SCALE = 2'd1;
   localparam logic [1:0] CSR_ACCEL_NOISE = 2'd2;

   localparam logic [31:0] GyroScaleReset  = 32'd79459;
   localparam logic [31:0] DriftScaleReset = 32'd3336000;
   localparam logic [31:0] NoiseReset      = 32'd838861;

   typedef struct packed {
      logic [31:0]        stamp;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] gx;
      logic signed [15:0] gy;
   } sample_type;

   // atan(2^-i) in 2^-20 degree
   function automatic logic [25:0] atan_entry(input logic [4:0] i);
      logic [25:0] r;
      begin
         unique case (i)
            5'd0: r = 26'd47185920;  5'd1: r = 26'd27855475;
            5'd2: r = 26'd14718068;  5'd3: r = 26'd7471121;
            5'd4: r = 26'd3750058;   5'd5: r = 26'd1876857;
            5'd6: r = 26'd938658;    5'd7: r = 26'd469357;
            5'd8: r = 26'd234682;    5'd9: r = 26'd117342;
            5'd10: r = 26'd58671;    5'd11: r = 26'd29335;
            5'd12: r = 26'd14668;    5'd13: r = 26'd7334;
            5'd14: r = 26'd3667;     5'd15: r = 26'd1833;
            5'd16: r = 26'd917;      5'd17: r = 26'd458;
            5'd18: r = 26'd229;      5'd19: r = 26'd115;
            5'd20: r = 26'd57;       5'd21: r = 26'd29;
            5'd22: r = 26'd14;       5'd23: r = 26'd7;
            5'd24: r = 26'd4;        5'd25: r = 26'd2;
            5'd26: r = 26'd1;
            default: r = 26'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [AngW-1:0] v);
      logic signed [31:0] r;
      begin
         if (v > 36'sd2147483647) r = 32'sh7fffffff;
         else if (v < -36'sd2147483648) r = 32'sh80000000;
         else r = v[31:0];
         return r;
      end
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/itke_queue.sv @@
`default_nettype none
module itke_queue
   import itke_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire sample_type push_data,
   output logic            full,
   input  wire logic       pop,
   output logic            not_empty,
   output sample_type      pop_data
);
   sample_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff[1];
   assign not_empty = cnt_ff != 2'd0;
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/itke_divider.sv @@
`default_nettype none
// restoring divider: quo = floor(num / den), 65-bit num, 33-bit den, one bit a cycle
module itke_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [64:0] num,
   input  wire logic [32:0] den,
   output logic             done,
   output logic [32:0]      quo
);
   logic [64:0] n_ff, n_in;
   logic [33:0] r_ff, r_in;
   logic [32:0] d_ff;
   logic [6:0]  c_ff, c_in;
   logic        busy_ff, busy_in;
   logic [33:0] sh;

   // quotient including the bit decided in the done cycle
   assign quo = n_in[32:0];

   always_comb begin
      sh = {r_ff[32:0], n_ff[64]};
      n_in = n_ff; r_in = r_ff; c_in = c_ff; busy_in = busy_ff; done = 1'b0;
      if (start) begin
         n_in = num; r_in = '0; c_in = 7'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            n_in = {n_ff[63:0], 1'b1};
         end else begin
            r_in = sh;
            n_in = {n_ff[63:0], 1'b0};
         end
         c_in = c_ff + 7'd1;
         if (c_ff == 7'd64) begin
            busy_in = 1'b0; done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; c_ff <= 7'd0;
      end else begin
         busy_ff <= busy_in; c_ff <= c_in;
      end
      n_ff <= n_in; r_ff <= r_in;
      if (start) d_ff <= den;
   end
endmodule
`default_nettype wire

@@ hw/rtl/itke_engine.sv @@
`default_nettype none
module itke_engine
   import itke_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] gyro_scale,
   input  wire logic [31:0] drift_scale,
   input  wire logic [31:0] noise,
   input  wire logic        item_valid,
   input  wire sample_type  item,
   output logic             item_pop,
   output logic             out_valid,
   input  wire logic        out_stall,
   output logic signed [31:0] roll_out,
   output logic signed [31:0] pitch_out
);
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_MUL1  = 10'b0000000010,
      ST_MUL2  = 10'b0000000100,
      ST_GYRO  = 10'b0000001000,
      ST_CPREP = 10'b0000010000,
      ST_CORD  = 10'b0000100000,
      ST_DIV   = 10'b0001000000,
      ST_CORR  = 10'b0010000000,
      ST_UNC   = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // tilt-state lanes: 0 roll (y=ay), 1 pitch (y=ax)
   logic [31:0]        stamp_ff;
   logic signed [31:0] est_ff [2];
   logic [31:0]        unc_ff;
   sample_type         s_ff;
   logic [31:0]        dt_ff;
   logic [47:0]        mag_ff [2];
   logic [32:0]        u_ff;
   logic signed [33:0] cx_ff [2], cy_ff [2];
   logic signed [AngW-1:0] cz_ff [2], base_ff [2];
   logic               zero_ff [2];
   logic [4:0]         it_ff;
   logic [32:0]        w_ff;

   logic        div_start, div_done;
   logic [32:0] div_quo;

   itke_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num({u_ff, 32'd0} + {33'd0, 32'd0} + 65'({1'b0, u_ff} + {1'b0, noise}) / 65'd2
           - 65'd0),
      .den(33'({1'b0, u_ff} + {2'b0, noise})),
      .done(div_done), .quo(div_quo)
   );

   assign item_pop  = (state_ff == ST_IDLE) && item_valid;
   assign out_valid = state_ff == ST_OUT;
   assign roll_out  = est_ff[0];
   assign pitch_out = est_ff[1];
   assign div_start = state_ff == ST_CPREP;

   // per-lane combinational helpers
   logic [15:0] rmag [2];
   logic signed [15:0] gsrc [2], ysrc [2];
   always_comb begin
      gsrc[0] = s_ff.gx; gsrc[1] = s_ff.gy;
      ysrc[0] = s_ff.ay; ysrc[1] = s_ff.ax;
      for (int k = 0; k < 2; k++) rmag[k] = gsrc[k][15] ? 16'(-gsrc[k]) : gsrc[k];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (item_valid) state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_GYRO;
         ST_GYRO:  state_in = ST_CPREP;
         ST_CPREP: state_in = ST_CORD;
         ST_CORD:  if (32'(it_ff) + 32'd1 >= CORDIC_STEPS) state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_CORR;
         ST_CORR:  state_in = ST_UNC;
         ST_UNC:   state_in = ST_OUT;
         ST_OUT:   if (!out_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   logic [63:0] glo [2];
   logic [47:0] ghi [2];
   logic [48:0] ginc [2];
   logic signed [50:0] gsum [2];
   logic signed [31:0] gsat [2];
   logic [63:0] dprod;
   logic [32:0] gd;
   logic [33:0] usum;
   logic signed [AngW:0] err [2];
   logic [AngW:0] emag [2];
   logic [AngW+32:0] cprod [2];
   logic [AngW+32:0] cd [2];
   logic signed [AngW+34:0] cnew [2];
   logic [65:0] uprod;
   logic signed [AngW-1:0] zr [2];
   logic signed [AngW-1:0] tgt [2];

   always_comb begin
      dprod = dt_ff * drift_scale;
      gd    = 33'(dprod[63:32]) + 33'(dprod[31]);
      usum  = {2'b0, unc_ff} + {1'b0, gd};
      uprod = u_ff * (33'h100000000 - w_ff);
      for (int k = 0; k < 2; k++) begin
         // gyro increment split into the low 32 and high 16 bits of the rate*dt magnitude
         glo[k]  = mag_ff[k][31:0] * gyro_scale;
         ghi[k]  = mag_ff[k][47:32] * gyro_scale;
         ginc[k] = 49'(ghi[k]) + 49'(glo[k][63:32]) + 49'(glo[k][31]);
         gsum[k] = gsrc[k][15] ? 51'(est_ff[k]) - 51'(ginc[k])
                               : 51'(est_ff[k]) + 51'(ginc[k]);
         gsat[k] = (gsum[k] > 51'sd2147483647) ? 32'sh7fffffff
                 : (gsum[k] < -51'sd2147483648) ? 32'sh80000000 : gsum[k][31:0];
         zr[k]   = (cz_ff[k] + AngW'(8)) >>> 4;
         tgt[k]  = zero_ff[k] ? '0 : base_ff[k] + zr[k];
         err[k]  = (AngW+1)'(tgt[k]) - (AngW+1)'(est_ff[k]);
         emag[k] = err[k][AngW] ? (AngW+1)'(-err[k]) : err[k];
         cprod[k] = emag[k] * w_ff[31:0];
         cd[k]    = w_ff[32] ? (AngW+33)'(emag[k])
                             : (AngW+33)'((cprod[k] + (AngW+33)'(33'h80000000)) >> 32);
         cnew[k]  = err[k][AngW] ? (AngW+35)'(est_ff[k]) - (AngW+35)'(cd[k])
                                 : (AngW+35)'(est_ff[k]) + (AngW+35)'(cd[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stamp_ff <= '0; unc_ff <= '0;
         est_ff[0] <= '0; est_ff[1] <= '0;
         it_ff <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (item_valid) begin
               s_ff     <= item;
               dt_ff    <= item.stamp - stamp_ff;
               stamp_ff <= item.stamp;
            end
            ST_MUL1: for (int k = 0; k < 2; k++) mag_ff[k] <= rmag[k] * dt_ff;
            ST_MUL2: u_ff <= usum[33:32] != 2'b0 ? 33'hffffffff : usum[32:0];
            ST_GYRO: for (int k = 0; k < 2; k++) est_ff[k] <= gsat[k];
            ST_CPREP: begin
               it_ff <= '0;
               for (int k = 0; k < 2; k++) begin
                  zero_ff[k] <= (s_ff.az == 0) && (ysrc[k] == 0);
                  cz_ff[k]   <= '0;
                  if (s_ff.az[15]) begin
                     base_ff[k] <= ysrc[k][15] ? -HalfTurn : HalfTurn;
                     cx_ff[k]   <= 34'(-34'(s_ff.az)) <<< 14;
                     cy_ff[k]   <= 34'(-34'(ysrc[k])) <<< 14;
                  end else begin
                     base_ff[k] <= '0;
                     cx_ff[k]   <= 34'(s_ff.az) <<< 14;
                     cy_ff[k]   <= 34'(ysrc[k]) <<< 14;
                  end
               end
            end
            ST_CORD: begin
               it_ff <= it_ff + 5'd1;
               for (int k = 0; k < 2; k++) begin
                  if (cy_ff[k] > 0) begin
                     cx_ff[k] <= cx_ff[k] + (cy_ff[k] >>> it_ff);
                     cy_ff[k] <= cy_ff[k] - (cx_ff[k] >>> it_ff);
                     cz_ff[k] <= cz_ff[k] + AngW'(atan_entry(it_ff));
                  end else begin
                     cx_ff[k] <= cx_ff[k] - (cy_ff[k] >>> it_ff);
                     cy_ff[k] <= cy_ff[k] + (cx_ff[k] >>> it_ff);
                     cz_ff[k] <= cz_ff[k] - AngW'(atan_entry(it_ff));
                  end
               end
            end
            // zero denominator gives no gain
            ST_DIV: if (div_done)
               w_ff <= (u_ff == 33'd0 && noise == 32'd0) ? 33'd0 : div_quo;
            ST_CORR: for (int k = 0; k < 2; k++)
               est_ff[k] <= sat32(AngW'(cnew[k] > (AngW+35)'(64'sh7fffffff) ? 64'sh7fffffff
                                 : cnew[k] < -(AngW+35)'(64'sh80000000) ? -64'sh80000000
                                 : cnew[k]));
            ST_UNC: begin
               if (w_ff[32]) unc_ff <= '0;
               else if (w_ff == 33'd0) unc_ff <= u_ff[31:0];
               else unc_ff <= 32'((uprod[65:31] + 35'd1) >> 1);
            end
            ST_OUT: ;
            default: ;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> state_ff == ST_MUL1) else $error("pop outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_stall |=> out_valid && $stable(roll_out)) else $error("result moved");
   a_w_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UNC |-> !(w_ff[32] && w_ff[31:0] != 32'd0)) else $error("gain range");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/imu_tilt_kalman_estimator_top.sv @@
`default_nettype none
// tilt estimator: one timestamped imu sample in on req_, one roll/pitch beat out on rsp_
// req_valid/req_stall: a beat is taken when valid and not stalled; a two-entry queue
// takes samples while the filter engine works on an earlier one.
// rsp_valid/rsp_stall: the result is held in output registers until taken.
// path from acceptance to rsp_valid with the engine idle: the queue register, four
// multiply and setup steps, a restoring division for the gain that runs beside the
// cordic loop (one iteration a cycle, both angles), then correction and uncertainty
// update.
// the engine, divider included, works on one sample at a time and pops the next from
// the queue only after its result is taken.
// while rsp is stalled the engine holds its result and the queue fills, then
// req_stall rises.
// reset (synchronous, high) clears timestamp, estimates and uncertainty to zero and the registers to their defaults;
// csr writes take effect from the next sample if the user makes them between samples; the block does not enforce this.
module imu_tilt_kalman_estimator_top
   import itke_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_timestamp,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_y,
   input  wire logic signed [15:0] req_accel_z,
   input  wire logic signed [15:0] req_rate_x,
   input  wire logic signed [15:0] req_rate_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_roll_angle,
   output logic signed [31:0] rsp_pitch_angle
);
   logic [31:0] gyro_ff, drift_ff, noise_ff;
   sample_type  in_item, q_item;
   logic        q_full, q_ne, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_ff <= GyroScaleReset; drift_ff <= DriftScaleReset; noise_ff <= NoiseReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GYRO_SCALE:  gyro_ff  <= csr_data;
            CSR_DRIFT_SCALE: drift_ff <= csr_data;
            CSR_ACCEL_NOISE: noise_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_item.stamp = req_timestamp;
      in_item.ax = req_accel_x; in_item.ay = req_accel_y; in_item.az = req_accel_z;
      in_item.gx = req_rate_x;  in_item.gy = req_rate_y;
   end

   assign req_stall = q_full;

   itke_queue u_queue (
      .clock(clock), .reset(reset),
      .push(req_valid && !q_full), .push_data(in_item), .full(q_full),
      .pop(q_pop), .not_empty(q_ne), .pop_data(q_item)
   );

   itke_engine #(.CORDIC_STEPS(CORDIC_STEPS)) u_engine (
      .clock(clock), .reset(reset),
      .gyro_scale(gyro_ff), .drift_scale(drift_ff), .noise(noise_ff),
      .item_valid(q_ne), .item(q_item), .item_pop(q_pop),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .roll_out(rsp_roll_angle), .pitch_out(rsp_pitch_angle)
   );
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
module testbench;
   import itke_pkg::*;

   localparam int LIMIT = 3_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_GYRO_SCALE;
   logic [31:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_timestamp = '0;
   logic signed [15:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic signed [15:0] req_rate_x = '0, req_rate_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_roll_angle, rsp_pitch_angle;

   always #5 clock = ~clock;

   imu_tilt_kalman_estimator_top dut (.*);

   class tilt_scoreboard;
      logic [31:0] gyro_scale, drift_scale, noise;
      logic [31:0] prev_stamp, uncert;
      logic signed [31:0] roll, pitch;
      logic signed [31:0] roll_q[$], pitch_q[$];
      int mismatches, seen;

      function new();
         gyro_scale = GyroScaleReset; drift_scale = DriftScaleReset; noise = NoiseReset;
         prev_stamp = 0; uncert = 0; roll = 0; pitch = 0;
         mismatches = 0; seen = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] v);
         if (idx == CSR_GYRO_SCALE) gyro_scale = v;
         else if (idx == CSR_DRIFT_SCALE) drift_scale = v;
         else if (idx == CSR_ACCEL_NOISE) noise = v;
      endfunction

      function logic signed [31:0] clamp(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function longint unsigned rnd32(longint unsigned p);
         return (p >> 32) + ((p >> 31) & 1);
      endfunction

      function longint shr(longint v, int s);
         return v >>> s;
      endfunction

      function longint rate_step(longint rate, logic [31:0] dt);
         longint unsigned mag, lo, hi;
         longint r;
         mag = (rate < 0 ? -rate : rate) * longint'({32'd0, dt});
         lo = (mag & 64'hffffffff) * {32'd0, gyro_scale};
         hi = (mag >> 32) * {32'd0, gyro_scale};
         r = hi + rnd32(lo);
         return rate < 0 ? -r : r;
      endfunction

      // cordic vectoring, table steps in 2^-20 degree, result in 2^-16 degree
      function longint atan_deg(longint y, longint x);
         longint base, z, nx;
         base = 0; z = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            base = (y >= 0) ? 180*65536 : -180*65536;
            x = -x; y = -y;
         end
         x *= 16384; y *= 16384;
         for (int i = 0; i < CordicStepsDefault; i++) begin
            if (y > 0) begin
               nx = x + shr(y, i); y = y - shr(x, i); z += atan_entry(i[4:0]);
            end else begin
               nx = x - shr(y, i); y = y + shr(x, i); z -= atan_entry(i[4:0]);
            end
            x = nx;
         end
         return base + shr(z + 8, 4);
      endfunction

      function logic signed [31:0] blend(logic signed [31:0] est, longint tgt,
                                         longint unsigned w);
         longint err;
         longint unsigned mag, d;
         err = tgt - longint'(est);
         mag = err < 0 ? -err : err;
         d = (w >= 64'h1_0000_0000) ? mag : rnd32(mag * w);
         return clamp(err < 0 ? longint'(est) - longint'(d) : longint'(est) + longint'(d));
      endfunction

      function void note_sample(logic [31:0] ts, logic signed [15:0] ax, ay, az, gx, gy);
         logic [31:0] dt;
         longint unsigned u, d, w;
         longint tr, tp;
         dt = ts - prev_stamp;
         prev_stamp = ts;
         roll = clamp(longint'(roll) + rate_step(gx, dt));
         pitch = clamp(longint'(pitch) + rate_step(gy, dt));
         u = uncert + rnd32({32'd0, dt} * {32'd0, drift_scale});
         if (u > 64'hffffffff) u = 64'hffffffff;
         tr = atan_deg(ay, az);
         tp = atan_deg(ax, az);
         d = u + noise;
         // u < 2^32 so the shifted numerator fits in 64 bits
         w = (d == 0) ? 0 : ((u << 32) + (d >> 1)) / d;
         roll = blend(roll, tr, w);
         pitch = blend(pitch, tp, w);
         if (w >= 64'h1_0000_0000) u = 0;
         else if (w != 0) u = rnd32(u * (64'h1_0000_0000 - w));
         uncert = u[31:0];
         roll_q.push_back(roll);
         pitch_q.push_back(pitch);
      endfunction

      function void check_result(logic signed [31:0] r, p);
         logic signed [31:0] er, ep;
         seen++;
         if (roll_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat roll=%0d pitch=%0d", r, p);
            return;
         end
         er = roll_q.pop_front();
         ep = pitch_q.pop_front();
         if (er !== r || ep !== p) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch beat %0d: roll exp %0d got %0d, pitch exp %0d got %0d",
                        seen, er, r, ep, p);
         end
      endfunction
   endclass

   tilt_scoreboard sb = new();
   int send_idle = 0, recv_idle = 0;
   longint cycles = 0;
   logic [31:0] stamp_now = 0;
   int sent = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_roll_angle, rsp_pitch_angle);
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL imu_tilt_kalman_estimator_top");
         $finish;
      end
   end

   // receiver stall randomized per cycle
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   task automatic write_reg(logic [1:0] idx, logic [31:0] v);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.write_reg(idx, v);
      @(negedge clock);
   endtask

   task automatic send_sample(logic [31:0] ts, logic signed [15:0] ax, ay, az, gx, gy);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1; req_timestamp <= ts;
      req_accel_x <= ax; req_accel_y <= ay; req_accel_z <= az;
      req_rate_x <= gx; req_rate_y <= gy;
      do @(posedge clock); while (req_stall);
      sb.note_sample(ts, ax, ay, az, gx, gy);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.roll_q.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic random_samples(int n);
      logic [31:0] step;
      logic signed [15:0] v[5];
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(3))
            0: step = $urandom;
            default: step = $urandom_range(200000);
         endcase
         stamp_now += step;
         foreach (v[j]) begin
            case ($urandom_range(4))
               0: v[j] = 16'($urandom);
               1: v[j] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
               2: v[j] = 16'($urandom_range(2) - 1);
               default: v[j] = 16'($signed(16'($urandom_range(4000))) - 2000);
            endcase
         end
         send_sample(stamp_now, v[0], v[1], v[2], v[3], v[4]);
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: zero vectors, axis signs, extremes, large gaps
      send_sample(0, 0, 0, 0, 0, 0);
      send_sample(100, 0, 0, -5, 0, 0);
      send_sample(200, 0, 0, 5, 0, 0);
      send_sample(300, 7, -9, 0, 0, 0);
      send_sample(400, -7, 9, -1, 0, 0);
      send_sample(500, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(600, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(32'hffffffff, 100, -100, 16'sh8000, 16'sh7fff, 16'sh8000);
      send_sample(32'h10, -300, 300, 1000, -1, 1);
      send_sample(32'h10, 1, 1, 1, 16'sh7fff, 16'sh8000);
      drain();
      write_reg(CSR_GYRO_SCALE, 32'hffffffff);
      write_reg(CSR_DRIFT_SCALE, 32'hffffffff);
      write_reg(CSR_ACCEL_NOISE, 32'hffffffff);
      send_sample(32'h8000_0000, 0, 0, 0, 16'sh7fff, 16'sh8000);
      send_sample(32'h0, 0, 0, 0, 16'sh7fff, 16'sh8000);
      send_sample(32'hffff_0000, 20, 30, 16'sh8000, 16'sh7fff, 16'sh8000);
      drain();
      write_reg(CSR_GYRO_SCALE, 0);
      write_reg(CSR_DRIFT_SCALE, 0);
      write_reg(CSR_ACCEL_NOISE, 1);
      send_sample(32'h1000, 50, -50, 2000, 500, -500);
      send_sample(32'h2000, -50, 50, -2000, 500, -500);
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 59; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 59; end
            default: begin send_idle = 15; recv_idle = 15; end
         endcase
         case (ph)
            0: ;
            4: begin
               write_reg(CSR_GYRO_SCALE, GyroScaleReset);
               write_reg(CSR_DRIFT_SCALE, DriftScaleReset);
               write_reg(CSR_ACCEL_NOISE, NoiseReset);
            end
            default: begin
               write_reg(CSR_GYRO_SCALE, $urandom_range(400000));
               write_reg(CSR_DRIFT_SCALE, $urandom);
               write_reg(CSR_ACCEL_NOISE, $urandom_range(1) ? $urandom : 1 + $urandom_range(9));
            end
         endcase
         random_samples(104);
         drain();
      end
      $display("sent %0d samples, checked %0d result beats across 8 register and idle phases",
               sent, sb.seen);
      if (sb.mismatches == 0 && sb.roll_q.size() == 0)
         $display("PASS imu_tilt_kalman_estimator_top");
      else
         $display("FAIL imu_tilt_kalman_estimator_top");
      $finish;
   end
endmodule
`default_nettype wire
